// ===== design/kmd5_pkg.sv =====
// Package for the keyed MD5-structured hash unit.
// Holds shared types, the round constant table and round helper functions.
// No dependencies.
package kmd5_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned RoundCount = 64;

   localparam logic [WordWidth-1:0] InitWord [4] = '{
      32'h67352301, 32'hefcdab79, 32'h98baccfe, 32'h11325476};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;
   localparam logic [5:0] LastPos = 6'd63;

   localparam logic [WordWidth-1:0] RoundConst [RoundCount] = '{
      32'hd76a5478, 32'he867b756, 32'h242073db, 32'hc18d3eee,
      32'hf57308af, 32'h4787c62a, 32'ha8384613, 32'hfd469501,
      32'h688098d8, 32'h8b44f7af, 32'hff8f5bb1, 32'h898cd7be,
      32'h6b901822, 32'hfd987193, 32'ha679438e, 32'h49740821,
      32'hf6112562, 32'hc540b340, 32'h265e4a51, 32'he9b4c7aa,
      32'hd627105d, 32'h02541453, 32'hd8a15681, 32'he7d3fbc8,
      32'h21e4cde6, 32'hc33707d6, 32'hf4d50387, 32'h455a14ed,
      32'ha933e905, 32'hfcefa3f8, 32'h676f01d9, 32'h8d294c8a,
      32'hf1fa3942, 32'h8771f681, 32'h6d3d6122, 32'hfde5380c,
      32'ha4be6a44, 32'h4bdec3a9, 32'hf6b84b60, 32'hbebfbc70,
      32'h28937ec6, 32'heaa127fa, 32'hd4ef8085, 32'h04881d05,
      32'hd9d4d339, 32'he66b99e5, 32'h1fa27cf8, 32'hc4ac3665,
      32'hf4342244, 32'h432a6f97, 32'hab9423a7, 32'hfc95a039,
      32'h655559c3, 32'h8f0ccc92, 32'hf5eff47d, 32'h85845dd1,
      32'h6fa57e4f, 32'hf52ce6e0, 32'ha3014514, 32'h4e0851a1,
      32'hf7557e82, 32'h453af235, 32'h2ad782bb, 32'heb56d391};

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_PAD,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LENGTH,
      ST_PREFETCH,
      ST_ROUND,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         byte_en;
      byte_src_type byte_src;
      logic         save_len;
      logic         prefetch;
      logic         round;
      logic         fold;
      logic         restart;
      logic [1:0]   out_index;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [5:0] pos;
      logic       last_round;
   } status_type;

   // Message word used by a given round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] i;
      i = rnd[3:0];
      case (rnd[5:4])
         2'd0:    msg_index = i;
         2'd1:    msg_index = 4'((i << 2) + i + 4'd1);
         2'd2:    msg_index = 4'((i << 1) + i + 4'd5);
         default: msg_index = 4'((i << 3) - i);
      endcase
   endfunction

   // Left rotation amount for a given round
   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      case ({rnd[5:4], rnd[1:0]})
         4'h0: rot_amount = 5'd7;
         4'h1: rot_amount = 5'd12;
         4'h2: rot_amount = 5'd17;
         4'h3: rot_amount = 5'd22;
         4'h4: rot_amount = 5'd5;
         4'h5: rot_amount = 5'd9;
         4'h6: rot_amount = 5'd14;
         4'h7: rot_amount = 5'd20;
         4'h8: rot_amount = 5'd4;
         4'h9: rot_amount = 5'd11;
         4'ha: rot_amount = 5'd16;
         4'hb: rot_amount = 5'd23;
         4'hc: rot_amount = 5'd6;
         4'hd: rot_amount = 5'd10;
         4'he: rot_amount = 5'd15;
         default: rot_amount = 5'd21;
      endcase
   endfunction

endpackage

// ===== design/kmd5_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kmd5_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kmd5_datapath.sv =====
// Datapath: key, chaining words, bit count, block word RAM and the round unit.
// Depends on kmd5_pkg and kmd5_ram.
module kmd5_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   input  logic [7:0]          in_byte,
   input  kmd5_pkg::cmd_type   cmd,
   output kmd5_pkg::status_type status,
   output logic [31:0]         digest_word
);
   import kmd5_pkg::*;

   logic [31:0] key_ff;
   logic [31:0] cv_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [63:0] count_ff, len_ff;
   logic [5:0]  pos_ff, rnd_ff;
   logic [23:0] hold_ff;
   logic [7:0]  byte_val;
   logic        wr_en;
   logic [3:0]  rd_addr;
   logic [31:0] rd_word;
   logic [31:0] f_val, t_sum, t_rot, new_b;
   logic [63:0] t_dbl;

   // Select the byte to absorb
   always_comb begin
      case (cmd.byte_src)
         SRC_INPUT:  byte_val = in_byte;
         SRC_PAD:    byte_val = PadByte;
         SRC_LENGTH: byte_val = len_ff[{pos_ff[2:0], 3'b000} +: 8];
         default:    byte_val = 8'h00;
      endcase
   end

   assign wr_en   = cmd.byte_en && (pos_ff[1:0] == 2'd3);
   assign rd_addr = cmd.prefetch ? msg_index(6'd0) : msg_index(rnd_ff + 6'd1);

   kmd5_ram #(
      .Width(WordWidth),
      .Depth(BlockWords)
   ) u_block_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff[5:2]),
      .wr_data({byte_val, hold_ff}),
      .rd_addr(rd_addr),
      .rd_data(rd_word)
   );

   // One round of the compression function
   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      t_sum = a_ff + f_val + rd_word + (RoundConst[rnd_ff] ^ key_ff);
      t_dbl = {t_sum, t_sum} << rot_amount(rnd_ff);
      t_rot = t_dbl[63:32];
      new_b = b_ff + t_rot;
   end

   // Key, chaining words and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         for (int i = 0; i < 4; i++) cv_ff[i] <= InitWord[i];
         count_ff <= '0;
         pos_ff   <= '0;
         rnd_ff   <= '0;
      end else if (csr_write_enable) begin
         key_ff   <= csr_write_data;
         for (int i = 0; i < 4; i++) cv_ff[i] <= InitWord[i] ^ csr_write_data;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         if (cmd.restart) begin
            for (int i = 0; i < 4; i++) cv_ff[i] <= InitWord[i] ^ key_ff;
            count_ff <= '0;
            pos_ff   <= '0;
         end
         if (cmd.byte_en) begin
            pos_ff <= pos_ff + 6'd1;
            if (cmd.byte_src != SRC_LENGTH) begin
               count_ff <= count_ff + 64'd8;
            end
         end
         if (cmd.prefetch) begin
            rnd_ff <= '0;
         end else if (cmd.round) begin
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (cmd.fold) begin
            cv_ff[0] <= cv_ff[0] + a_ff;
            cv_ff[1] <= cv_ff[1] + b_ff;
            cv_ff[2] <= cv_ff[2] + c_ff;
            cv_ff[3] <= cv_ff[3] + d_ff;
         end
      end
   end

   // Payload registers: working words, saved length, partial word
   always_ff @(posedge clock) begin
      if (cmd.save_len) begin
         len_ff <= count_ff;
      end
      if (cmd.byte_en) begin
         case (pos_ff[1:0])
            2'd0:    hold_ff[7:0]   <= byte_val;
            2'd1:    hold_ff[15:8]  <= byte_val;
            2'd2:    hold_ff[23:16] <= byte_val;
            default: hold_ff        <= hold_ff;
         endcase
      end
      if (cmd.prefetch) begin
         a_ff <= cv_ff[0];
         b_ff <= cv_ff[1];
         c_ff <= cv_ff[2];
         d_ff <= cv_ff[3];
      end else if (cmd.round) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= new_b;
      end
   end

   assign status.pos        = pos_ff;
   assign status.last_round = (rnd_ff == 6'(RoundCount - 1));
   assign digest_word       = cv_ff[cmd.out_index];

   // Restart leaves the block position at zero
   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (pos_ff == 6'd0))
      else $error("block position not cleared by restart");

   // A word is written only on the fourth byte of a word
   a_word_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cmd.byte_en && pos_ff[1:0] == 2'd3))
      else $error("word write off a word boundary");

   // Rounds run in order from the prefetch
   a_round_order: assert property (@(posedge clock) disable iff (reset)
      cmd.prefetch |=> (rnd_ff == 6'd0))
      else $error("round counter not cleared by prefetch");

endmodule

// ===== design/kmd5_ctrl.sv =====
// Controller: sequences absorb, padding, compression rounds and digest output.
// Depends on kmd5_pkg.
module kmd5_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           word_index,
   output logic                 last_word,
   input  kmd5_pkg::status_type status,
   output kmd5_pkg::cmd_type    cmd
);
   import kmd5_pkg::*;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [1:0] idx_ff, idx_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.byte_src  = SRC_ZERO;
      cmd.out_index = idx_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind) begin
                  cmd.save_len = 1'b1;
                  state_in     = ST_PAD;
               end else begin
                  cmd.byte_en  = 1'b1;
                  cmd.byte_src = SRC_INPUT;
                  if (status.pos == LastPos) begin
                     ret_in   = ST_IDLE;
                     state_in = ST_PREFETCH;
                  end
               end
            end
         end
         ST_PAD: begin
            cmd.byte_en  = 1'b1;
            cmd.byte_src = SRC_PAD;
            ret_in       = ST_ZERO;
            state_in     = (status.pos == LastPos) ? ST_PREFETCH : ST_ZERO;
         end
         ST_ZERO: begin
            if (status.pos == LenPos) begin
               state_in = ST_LENGTH;
            end else begin
               cmd.byte_en  = 1'b1;
               cmd.byte_src = SRC_ZERO;
               if (status.pos == LastPos) begin
                  ret_in   = ST_ZERO;
                  state_in = ST_PREFETCH;
               end
            end
         end
         ST_LENGTH: begin
            cmd.byte_en  = 1'b1;
            cmd.byte_src = SRC_LENGTH;
            if (status.pos == LastPos) begin
               ret_in   = ST_OUTPUT;
               state_in = ST_PREFETCH;
            end
         end
         ST_PREFETCH: begin
            cmd.prefetch = 1'b1;
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.last_round) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            idx_in   = '0;
            state_in = ret_ff;
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign word_index = idx_ff;
   assign last_word  = (idx_ff == 2'd3);

   // No new transaction while the digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during digest output");

   // Digest output starts at word zero
   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (idx_ff == 2'd0))
      else $error("digest output does not start at word zero");

   // Restart follows only the last word
   a_restart_last: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |-> (rsp_valid && rsp_ready && last_word))
      else $error("restart without last word taken");

endmodule

// ===== design/keyed_md5_variant_hash_unit.sv =====
// Top level of the keyed MD5-structured hash unit.
// Depends on kmd5_pkg, kmd5_ctrl and kmd5_datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  req     | req_valid req_ready req_kind req_data_byte| in
//  rsp     | rsp_valid rsp_ready rsp_digest_word       | out
//          | rsp_word_index rsp_last_word              |
//  csr     | csr_write_enable csr_write_data           | in
//
// Data bytes are taken while idle; a byte that fills the block starts a compression
// (one prefetch, 64 rounds on the single round unit, one fold) with req held off.
// Finish walks the padding byte by byte, compresses once or twice,
// then shows four digest words, one per rsp transaction.
// Reset is synchronous; the key clears to zero and the message restarts.
// A stalled rsp holds the current word; req is held off until the digest is out.
module keyed_md5_variant_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import kmd5_pkg::*;

   cmd_type    cmd;
   status_type status;

   kmd5_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .word_index(rsp_word_index),
      .last_word (rsp_last_word),
      .status    (status),
      .cmd       (cmd)
   );

   kmd5_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .in_byte         (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .digest_word     (rsp_digest_word)
   );

endmodule

// ===== tb/kmd5_digest_checker.sv =====
// Digest checker for the keyed MD5-structured hash unit: watches req, rsp and csr,
// computes the expected digest words and compares each rsp transaction.
// Depends on kmd5_pkg for the initial words and the round constant table.
`timescale 1ns / 100ps

module kmd5_digest_checker
   import kmd5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [1:0]  rsp_word_index,
   input  logic        rsp_last_word,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending_words
);

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   localparam logic [4:0] ShiftTable [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

   logic [31:0]     key_q;
   logic [31:0]     chain_q [4];
   logic [7:0]      msg_block [64];
   logic [63:0]     msg_bits;
   digest_word_type digest_fifo [$];

   function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
      return (x << n) | (x >> (6'd32 - n));
   endfunction

   // Compress the current block into the chaining words
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t;
      int          g;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
      a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin f = (b & c) | (~b & d); g = i; end
            1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
         endcase
         t = a + f + w[g] + (RoundConst[i] ^ key_q);
         t = b + rol32(t, ShiftTable[(i/16)*4 + i%4]);
         a = d; d = c; c = b; b = t;
      end
      chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
   endtask

   task automatic absorb_byte(input logic [7:0] v);
      logic [5:0] pos;
      pos = msg_bits[8:3];
      msg_block[pos] = v;
      msg_bits += 64'd8;
      if (pos == 6'd63) compress_block();
   endtask

   task automatic restart_message();
      for (int i = 0; i < 4; i++) chain_q[i] = InitWord[i] ^ key_q;
      msg_bits = '0;
   endtask

   // Pad, append the length, and queue the four digest words
   task automatic finish_message();
      logic [63:0]     saved;
      digest_word_type e;
      saved = msg_bits;
      absorb_byte(PadByte);
      while (msg_bits[8:3] != LenPos) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) msg_block[56+i] = saved[8*i +: 8];
      compress_block();
      for (int i = 0; i < 4; i++) begin
         e.word = chain_q[i]; e.index = 2'(i); e.last = (i == 3);
         digest_fifo.push_back(e);
      end
      restart_message();
   endtask

   initial begin
      fail_count    = 0;
      pending_words = 0;
   end

   always @(posedge clock) begin
      digest_word_type e;
      if (reset) begin
         key_q = '0;
         restart_message();
         digest_fifo.delete();
      end else begin
         if (csr_write_enable) begin
            key_q = csr_write_data;
            restart_message();
         end
         if (req_valid && req_ready) begin
            if (req_kind) finish_message();
            else absorb_byte(req_data_byte);
         end
         // Compare each digest word with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (digest_fifo.size() == 0) begin
               $error("unexpected digest word %h", rsp_digest_word);
               fail_count++;
            end else begin
               e = digest_fifo.pop_front();
               if (rsp_digest_word !== e.word) begin
                  $error("digest_word expected %h actual %h", e.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== e.index) begin
                  $error("word_index expected %0d actual %0d", e.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== e.last) begin
                  $error("last_word expected %0d actual %0d", e.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
      pending_words = digest_fifo.size();
   end

endmodule

// ===== tb/tb_keyed_md5_variant_hash_unit.sv =====
// Testbench top for the keyed MD5-structured hash unit: drives messages and keys.
// Depends on kmd5_pkg, keyed_md5_variant_hash_unit and kmd5_digest_checker.
`timescale 1ns / 100ps

module tb_keyed_md5_variant_hash_unit;
   import kmd5_pkg::*;

   localparam logic KindByte   = 1'b0;
   localparam logic KindFinish = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = KindByte;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   int          fail_count;
   int          pending_words;
   bit          calm = 1'b0;
   int          sent = 0;

   always #2 clock = ~clock;

   keyed_md5_variant_hash_unit dut (.*);

   kmd5_digest_checker checker_i (.*);

   // Receiver stalls about a quarter of the time except in calm stretches
   always @(posedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 25);

   // Send one transaction, with a random gap before it; valid drops only in a gap
   task automatic send_item(input logic kind, input logic [7:0] data);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_message(input int len, input bit ones);
      for (int i = 0; i < len; i++)
         send_item(KindByte, ones ? 8'hff : 8'($urandom));
      send_item(KindFinish, 8'($urandom));
   endtask

   // Drop valid, wait for all digests, then let the block settle before a key write
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_key(input logic [31:0] k);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty message, short lengths, extreme bytes
      send_message(0, 0);
      send_message(1, 1);
      send_item(KindByte, 8'h00);
      send_item(KindFinish, 8'hff);
      write_key(32'hffffffff);
      send_message(0, 0);
      send_message(3, 1);
      write_key(32'h00000000);
      send_message(8, 0);
      // Random messages, lengths include ranges around the 55/56/64 and 119/120/128 byte boundaries
      while (sent < 220) begin
         if ($urandom_range(9) == 0) write_key($urandom);
         if ($urandom_range(7) == 0) drain();
         calm = ($urandom_range(9) == 0);
         case ($urandom_range(3))
            0: send_message($urandom_range(0, 8), $urandom_range(9) == 0);
            1: send_message($urandom_range(53, 66), 0);
            2: send_message($urandom_range(119, 130), 0);
            default: send_message($urandom_range(9, 40), 0);
         endcase
      end
      calm = 1'b0;
      write_key(32'h80000001);
      // Long stretch with no idling on either side
      calm = 1'b1;
      send_message(56, 0);
      drain();
      if (fail_count == 0)
         $display("[keyed_md5_variant_hash_unit] OK");
      else
         $display("[keyed_md5_variant_hash_unit] ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("[keyed_md5_variant_hash_unit] ERROR");
      $finish;
   end

endmodule
